/* sv/qrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// shared constants and status codes of the quadratic root solver
// ----------------------------------------------------------------------------
package qrs_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 16;

  // discriminant tolerance register
  localparam int unsigned TOL_WIDTH = 16;
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = 16'd1;

  localparam int unsigned STATUS_WIDTH = 2;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK       = 2'd0,
    ST_NEG_DISC = 2'd1,
    ST_A_ZERO   = 2'd2,
    ST_SAT      = 2'd3
  } status_e;

endpackage

/* sv/quadratic_root_solver_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit
// fixed point roots of a*x^2 + b*x + c, one coefficient set per beat
// throughput: one beat per cycle while no result waits unread; the root stage
// (one bit per stage) and the two restoring dividers (one quotient bit per
// stage) are fully pipelined
// reset: asynchronous, active low; clears all valid bits and loads the
// tolerance register with 1
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit #(
  parameter int unsigned DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF,
  localparam int unsigned IN_TDW    = ((3*DATA_WIDTH+7)/8)*8,
  localparam int unsigned OUT_TDW   = ((2*DATA_WIDTH+7)/8)*8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // tolerance register write
  input  logic                                cfg_we_i,
  input  logic [qrs_pkg::TOL_WIDTH-1:0]       cfg_wdata_i,
  // coefficient stream
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [IN_TDW-1:0]                   s_axis_tdata_i,  // coef_a, coef_b, coef_c
  // root stream
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [OUT_TDW-1:0]                  m_axis_tdata_o,  // root_minus, root_plus
  output logic [qrs_pkg::STATUS_WIDTH-1:0]    m_axis_tuser_o   // status
);

  localparam int DW   = DATA_WIDTH;
  localparam int FW   = FRAC_BITS;
  localparam int PW   = 2*DW;          // product width
  localparam int RW   = 2*DW + 2;      // radicand width (even)
  localparam int SW   = DW + 1;        // root width, one stage per bit
  localparam int REMW = DW + 4;        // root remainder
  localparam int NW   = DW + 3;        // signed numerator -b -/+ s
  localparam int NMW  = DW + 2;        // numerator magnitude
  localparam int DENW = DW + 1;        // |2a|
  localparam int DVW  = NMW + FW;      // dividend |num| << frac
  localparam int CW   = ((DVW > DENW+DW) ? DVW : DENW+DW) + 1;
  localparam int DRW  = DENW + 1;      // divider remainder

  typedef struct packed {
    qrs_pkg::status_e     status;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] b;
  } side_t;

  // global advance: the whole pipe moves unless a result waits unread
  logic adv;
  logic out_v_q;
  assign adv             = !out_v_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  // tolerance register
  logic [qrs_pkg::TOL_WIDTH-1:0] tol_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= qrs_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------- stage 0
  // magnitudes of the coefficients
  logic signed [DW-1:0] in_a, in_b, in_c;
  assign in_a = s_axis_tdata_i[DW-1:0];
  assign in_b = s_axis_tdata_i[2*DW-1:DW];
  assign in_c = s_axis_tdata_i[3*DW-1:2*DW];

  logic                 p0_v_q;
  logic signed [DW-1:0] p0_a_q, p0_b_q;
  logic [DW-1:0]        p0_ma_q, p0_mb_q, p0_mc_q;
  logic                 p0_sdiff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_v_q <= 1'b0;
    end else if (adv) begin
      p0_v_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p0_a_q     <= in_a;
      p0_b_q     <= in_b;
      p0_ma_q    <= in_a[DW-1] ? DW'(-in_a) : DW'(in_a);
      p0_mb_q    <= in_b[DW-1] ? DW'(-in_b) : DW'(in_b);
      p0_mc_q    <= in_c[DW-1] ? DW'(-in_c) : DW'(in_c);
      p0_sdiff_q <= in_a[DW-1] ^ in_c[DW-1];
    end
  end

  // ---------------------------------------------------------------- stage 1
  // b*b and |a*c|
  logic                 p1_v_q;
  logic signed [DW-1:0] p1_a_q, p1_b_q;
  logic [PW-1:0]        p1_bb_q, p1_ac_q;
  logic                 p1_sdiff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (adv) begin
      p1_v_q <= p0_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_a_q     <= p0_a_q;
      p1_b_q     <= p0_b_q;
      p1_bb_q    <= PW'(p0_mb_q) * PW'(p0_mb_q);
      p1_ac_q    <= PW'(p0_ma_q) * PW'(p0_mc_q);
      p1_sdiff_q <= p0_sdiff_q;
    end
  end

  // ---------------------------------------------------------------- stage 2
  // discriminant, tolerance snap and early status
  logic [RW-1:0]    bb_w, ac4_w, tol_w, disc, rad_d;
  logic             disc_neg, disc_small;
  qrs_pkg::status_e st_d;

  always_comb begin
    bb_w     = RW'(p1_bb_q);
    ac4_w    = {p1_ac_q, 2'b00};
    tol_w    = RW'(tol_q);
    disc_neg = 1'b0;
    if (p1_sdiff_q) begin
      disc = bb_w + ac4_w;
    end else if (bb_w >= ac4_w) begin
      disc = bb_w - ac4_w;
    end else begin
      disc     = ac4_w - bb_w;
      disc_neg = 1'b1;
    end
    disc_small = disc < tol_w;
    rad_d      = disc_small ? '0 : disc;
    // negative discriminant wins over zero a
    if (disc_neg && !disc_small) begin
      st_d = qrs_pkg::ST_NEG_DISC;
    end else if (p1_a_q == '0) begin
      st_d = qrs_pkg::ST_A_ZERO;
    end else begin
      st_d = qrs_pkg::ST_OK;
    end
  end

  logic          p2_v_q;
  logic [RW-1:0] p2_rad_q;
  side_t         p2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (adv) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p2_rad_q         <= rad_d;
      p2_side_q.status <= st_d;
      p2_side_q.a      <= p1_a_q;
      p2_side_q.b      <= p1_b_q;
    end
  end

  // ------------------------------------------------------------ square root
  // digit by digit, two radicand bits and one root bit per stage
  logic            sq_v_q    [SW];
  logic [RW-1:0]   sq_rad_q  [SW];
  logic [REMW-1:0] sq_rem_q  [SW];
  logic [SW-1:0]   sq_root_q [SW];
  side_t           sq_side_q [SW];

  for (genvar k = 0; k < SW; k++) begin : g_sqrt
    logic            v_in;
    logic [RW-1:0]   rad_in;
    logic [REMW-1:0] rem_in, rem_sh, trial;
    logic [SW-1:0]   root_in;
    side_t           side_in;

    if (k == 0) begin : g_first
      assign v_in    = p2_v_q;
      assign rad_in  = p2_rad_q;
      assign rem_in  = '0;
      assign root_in = '0;
      assign side_in = p2_side_q;
    end else begin : g_next
      assign v_in    = sq_v_q[k-1];
      assign rad_in  = sq_rad_q[k-1];
      assign rem_in  = sq_rem_q[k-1];
      assign root_in = sq_root_q[k-1];
      assign side_in = sq_side_q[k-1];
    end

    assign rem_sh = {rem_in[REMW-3:0], rad_in[RW-1 -: 2]};
    assign trial  = REMW'({root_in, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[k] <= 1'b0;
      end else if (adv) begin
        sq_v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_rad_q[k]  <= rad_in << 2;
        sq_side_q[k] <= side_in;
        if (rem_sh >= trial) begin
          sq_rem_q[k]  <= rem_sh - trial;
          sq_root_q[k] <= {root_in[SW-2:0], 1'b1};
        end else begin
          sq_rem_q[k]  <= rem_sh;
          sq_root_q[k] <= {root_in[SW-2:0], 1'b0};
        end
      end
    end
  end

  // ---------------------------------------------------------------- stage 3
  // numerators -b -/+ s, their magnitudes and the quotient signs
  side_t                sq_side;
  logic signed [NW-1:0] nb, num_m, num_p;
  logic [NMW-1:0]       mag_m, mag_p;
  logic                 neg_m, neg_p;
  logic [DW-1:0]        mag_a;

  always_comb begin
    sq_side = sq_side_q[SW-1];
    nb      = -NW'(sq_side.b);
    num_m   = nb - NW'(sq_root_q[SW-1]);
    num_p   = nb + NW'(sq_root_q[SW-1]);
    neg_m   = (num_m[NW-1] != sq_side.a[DW-1]) && (num_m != '0);
    neg_p   = (num_p[NW-1] != sq_side.a[DW-1]) && (num_p != '0);
    mag_m   = num_m[NW-1] ? NMW'(-num_m) : NMW'(num_m);
    mag_p   = num_p[NW-1] ? NMW'(-num_p) : NMW'(num_p);
    mag_a   = sq_side.a[DW-1] ? DW'(-sq_side.a) : DW'(sq_side.a);
  end

  logic             p3_v_q;
  qrs_pkg::status_e p3_st_q;
  logic [NMW-1:0]   p3_mag_q [2];
  logic             p3_neg_q [2];
  logic [DENW-1:0]  p3_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (adv) begin
      p3_v_q <= sq_v_q[SW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p3_st_q     <= sq_side.status;
      p3_mag_q[0] <= mag_m;
      p3_mag_q[1] <= mag_p;
      p3_neg_q[0] <= neg_m;
      p3_neg_q[1] <= neg_p;
      p3_den_q    <= {mag_a, 1'b0};
    end
  end

  // ---------------------------------------------------------------- stage 4
  // overflow precheck: a quotient of 2^DW or more saturates anyway, so the
  // dividers only need the low DW quotient bits
  logic [DVW-1:0] dvd      [2];
  logic [CW-1:0]  dvd_w    [2];
  logic [CW-1:0]  den_top;
  logic [CW-1:0]  rem_init [2];

  always_comb begin
    den_top = CW'(p3_den_q) << DW;
    for (int l = 0; l < 2; l++) begin
      dvd[l]      = {p3_mag_q[l], {FW{1'b0}}};
      dvd_w[l]    = CW'(dvd[l]);
      rem_init[l] = dvd_w[l] >> DW;
    end
  end

  logic             p4_v_q;
  qrs_pkg::status_e p4_st_q;
  logic [DRW-1:0]   p4_rem_q [2];
  logic [DW-1:0]    p4_low_q [2];
  logic             p4_ovf_q [2];
  logic             p4_neg_q [2];
  logic [DENW-1:0]  p4_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p4_v_q <= 1'b0;
    end else if (adv) begin
      p4_v_q <= p3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p4_st_q  <= p3_st_q;
      p4_den_q <= p3_den_q;
      for (int l = 0; l < 2; l++) begin
        p4_rem_q[l] <= rem_init[l][DRW-1:0];
        p4_low_q[l] <= dvd[l][DW-1:0];
        p4_ovf_q[l] <= dvd_w[l] >= den_top;
        p4_neg_q[l] <= p3_neg_q[l];
      end
    end
  end

  // -------------------------------------------------------------- dividers
  // restoring division, both roots side by side, one quotient bit per stage
  logic             dv_v_q   [DW];
  qrs_pkg::status_e dv_st_q  [DW];
  logic [DENW-1:0]  dv_den_q [DW];
  logic [DRW-1:0]   dv_rem_q [DW][2];
  logic [DW-1:0]    dv_low_q [DW][2];
  logic [DW-1:0]    dv_quo_q [DW][2];
  logic             dv_ovf_q [DW][2];
  logic             dv_neg_q [DW][2];

  for (genvar j = 0; j < DW; j++) begin : g_div
    logic             v_in;
    qrs_pkg::status_e st_in;
    logic [DENW-1:0]  den_in;
    logic [DRW-1:0]   rem_in [2];
    logic [DW-1:0]    low_in [2];
    logic [DW-1:0]    quo_in [2];
    logic             ovf_in [2];
    logic             neg_in [2];
    logic [DRW-1:0]   r2     [2];
    logic [DRW-1:0]   den_x;
    logic             ge     [2];

    if (j == 0) begin : g_first
      assign v_in   = p4_v_q;
      assign st_in  = p4_st_q;
      assign den_in = p4_den_q;
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_in[l] = p4_rem_q[l];
        assign low_in[l] = p4_low_q[l];
        assign quo_in[l] = '0;
        assign ovf_in[l] = p4_ovf_q[l];
        assign neg_in[l] = p4_neg_q[l];
      end
    end else begin : g_next
      assign v_in   = dv_v_q[j-1];
      assign st_in  = dv_st_q[j-1];
      assign den_in = dv_den_q[j-1];
      for (genvar l = 0; l < 2; l++) begin : g_lane
        assign rem_in[l] = dv_rem_q[j-1][l];
        assign low_in[l] = dv_low_q[j-1][l];
        assign quo_in[l] = dv_quo_q[j-1][l];
        assign ovf_in[l] = dv_ovf_q[j-1][l];
        assign neg_in[l] = dv_neg_q[j-1][l];
      end
    end

    assign den_x = DRW'(den_in);

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        r2[l] = {rem_in[l][DRW-2:0], low_in[l][DW-1]};
        ge[l] = r2[l] >= den_x;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j] <= 1'b0;
      end else if (adv) begin
        dv_v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_st_q[j]  <= st_in;
        dv_den_q[j] <= den_in;
        for (int l = 0; l < 2; l++) begin
          dv_rem_q[j][l] <= ge[l] ? r2[l] - den_x : r2[l];
          dv_low_q[j][l] <= low_in[l] << 1;
          dv_quo_q[j][l] <= {quo_in[l][DW-2:0], ge[l]};
          dv_ovf_q[j][l] <= ovf_in[l];
          dv_neg_q[j][l] <= neg_in[l];
        end
      end
    end
  end

  // ---------------------------------------------------------- output stage
  // floor towards minus infinity, saturate, sign and pick the status
  logic [DW:0]      quo_up [2];
  logic [DW:0]      lim    [2];
  logic [DW:0]      sel    [2];
  logic             sat    [2];
  logic [DW-1:0]    root_d [2];
  qrs_pkg::status_e st_out_d;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      quo_up[l] = (DW+1)'(dv_quo_q[DW-1][l])
                + (DW+1)'(dv_neg_q[DW-1][l] && (dv_rem_q[DW-1][l] != '0));
      lim[l]    = dv_neg_q[DW-1][l] ? ((DW+1)'(1) << (DW-1))
                                     : ((DW+1)'(1) << (DW-1)) - (DW+1)'(1);
      sat[l]    = dv_ovf_q[DW-1][l] || (quo_up[l] > lim[l]);
      sel[l]    = sat[l] ? lim[l] : quo_up[l];
      root_d[l] = dv_neg_q[DW-1][l] ? DW'(-sel[l]) : DW'(sel[l]);
    end
    if (dv_st_q[DW-1] != qrs_pkg::ST_OK) begin
      st_out_d  = dv_st_q[DW-1];
      root_d[0] = '0;
      root_d[1] = '0;
    end else if (sat[0] || sat[1]) begin
      st_out_d  = qrs_pkg::ST_SAT;
    end else begin
      st_out_d  = qrs_pkg::ST_OK;
    end
  end

  logic [DW-1:0]    out_rm_q, out_rp_q;
  qrs_pkg::status_e out_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv) begin
      out_v_q <= dv_v_q[DW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_rm_q <= root_d[0];
      out_rp_q <= root_d[1];
      out_st_q <= st_out_d;
    end
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = OUT_TDW'({out_rp_q, out_rm_q});
  assign m_axis_tuser_o  = out_st_q;

endmodule

/* sv/qrs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_checker
// port level checks of the quadratic root solver, bound to the top level
// ----------------------------------------------------------------------------
module qrs_checker #(
  parameter int unsigned DATA_WIDTH = qrs_pkg::DATA_WIDTH_DEF,
  localparam int unsigned OUT_TDW   = ((2*DATA_WIDTH+7)/8)*8
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tready_o,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [OUT_TDW-1:0]               m_axis_tdata_o,
  input logic [qrs_pkg::STATUS_WIDTH-1:0] m_axis_tuser_o
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result beat changed while stalled");

  // an empty output stage never blocks the input
  a_in_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output stage");

  // rejected sets carry zero roots
  a_zero_roots: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == qrs_pkg::ST_NEG_DISC ||
                        m_axis_tuser_o == qrs_pkg::ST_A_ZERO)
      |-> m_axis_tdata_o[2*DATA_WIDTH-1:0] == '0)
    else $error("nonzero roots with rejected status");

endmodule

bind quadratic_root_solver_unit qrs_checker #(
  .DATA_WIDTH (DATA_WIDTH)
) u_qrs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

/* dv/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quadratic root solver: a directed table of
// coefficient sets, then random sets over several tolerance settings, each
// result checked against a typed-in expectation or a bit-exact root predictor
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DW        = 32;
  localparam int unsigned LATENCY   = 2*DW+7;
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned N_PHASE   = 475;
  localparam int unsigned HOLD_LEN  = 400;

  typedef struct {
    logic [DW-1:0]    root_minus;
    logic [DW-1:0]    root_plus;
    qrs_pkg::status_e status;
  } roots_t;

  typedef struct {
    logic signed [DW-1:0] a, b, c;
    bit                   fixed;  // expected result typed in below
    roots_t               res;
  } coef_row_t;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            cfg_we_i = 1'b0;
  logic [qrs_pkg::TOL_WIDTH-1:0]   cfg_wdata_i = '0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [3*DW-1:0]                 s_axis_tdata_i = '0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [2*DW-1:0]                 m_axis_tdata_o;
  logic [qrs_pkg::STATUS_WIDTH-1:0] m_axis_tuser_o;

  logic [qrs_pkg::TOL_WIDTH-1:0] tol_model = qrs_pkg::TOL_RESET;
  roots_t               pending_roots[$];
  int unsigned          n_errors = 0;
  int unsigned          idle_pct = 0;
  int unsigned          stall_pct = 0;
  int unsigned          hold_cnt = 0;
  int unsigned          wdog = 0;

  quadratic_root_solver_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // floor square root of the wide discriminant
  function automatic logic [63:0] isqrt_wide(input logic [127:0] d);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if ({64'd0, t} * {64'd0, t} <= d) r = t;
    end
    return r;
  endfunction

  // floor(num * 2^16 / den) saturated to 32 bits
  function automatic logic [DW-1:0] root_floor(input logic signed [127:0] num,
                                               input logic signed [127:0] den,
                                               inout bit sat);
    logic [127:0] n_mag;
    logic [127:0] d_mag;
    logic [127:0] q;
    logic [127:0] lim;
    bit           neg;
    neg   = (num < 0) != (den < 0);
    if (num == 0) neg = 1'b0;
    n_mag = (num < 0) ? -num : num;
    d_mag = (den < 0) ? -den : den;
    q     = (n_mag << 16) / d_mag;
    if (neg && ((n_mag << 16) % d_mag) != 0) q = q + 1;
    lim   = neg ? (128'd1 << (DW-1)) : (128'd1 << (DW-1)) - 1;
    if (q > lim) begin
      sat = 1'b1;
      q   = lim;
    end
    return neg ? DW'(-q) : DW'(q);
  endfunction

  function automatic roots_t solve_roots(input logic signed [DW-1:0] a,
                                         input logic signed [DW-1:0] b,
                                         input logic signed [DW-1:0] c);
    roots_t                r;
    logic [127:0]          a_mag, b_mag, c_mag, bb, ac4, d;
    logic [63:0]           s;
    logic signed [127:0]   nb, den;
    bit                    dneg, sat;
    a_mag = (a < 0) ? -128'(a) : 128'(a);
    b_mag = (b < 0) ? -128'(b) : 128'(b);
    c_mag = (c < 0) ? -128'(c) : 128'(c);
    bb    = b_mag * b_mag;
    ac4   = (a_mag * c_mag) << 2;
    dneg  = 1'b0;
    sat   = 1'b0;
    r     = '{default: '0, status: qrs_pkg::ST_OK};
    if ((a < 0) != (c < 0)) d = bb + ac4;
    else if (bb >= ac4) d = bb - ac4;
    else begin
      d    = ac4 - bb;
      dneg = 1'b1;
    end
    if (dneg && d >= 128'(tol_model)) begin
      r.status = qrs_pkg::ST_NEG_DISC;
      return r;
    end
    if (d < 128'(tol_model)) d = '0;
    if (a == 0) begin
      r.status = qrs_pkg::ST_A_ZERO;
      return r;
    end
    s   = isqrt_wide(d);
    nb  = -128'(b);
    den = 2 * 128'(a);
    r.root_minus = root_floor(nb - $signed({64'd0, s}), den, sat);
    r.root_plus  = root_floor(nb + $signed({64'd0, s}), den, sat);
    r.status     = sat ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
    return r;
  endfunction

  // offer one coefficient set and wait for its beat
  task automatic send_coefs(input logic signed [DW-1:0] a, input logic signed [DW-1:0] b,
                            input logic signed [DW-1:0] c, input bit fixed,
                            input roots_t fixed_res);
    roots_t r;
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {c, b, a};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    r = fixed ? fixed_res : solve_roots(a, b, c);
    pending_roots.push_back(r);
  endtask

  task automatic write_tol(input logic [qrs_pkg::TOL_WIDTH-1:0] v);
    s_axis_tvalid_i <= 1'b0;
    wait (pending_roots.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    tol_model = v;
  endtask

  // random coefficient set, drawn from full-range, narrow, near-double-root, zero-a and c-equals-a classes
  task automatic send_random();
    logic signed [DW-1:0] a, b, c, t;
    roots_t               none;
    none = '{default: '0, status: qrs_pkg::ST_OK};
    case ($urandom_range(9))
      0, 1, 2: begin
        a = $urandom; b = $urandom; c = $urandom;
      end
      3, 4: begin
        a = $signed(20'($urandom)); b = $signed(24'($urandom));
        c = $signed(20'($urandom));
      end
      5, 6, 7: begin
        // near-double root: b*b close to 4ac, delta probes the tolerance
        a = $signed(13'($urandom));
        if (a == 0) a = 1;
        t = $signed(9'($urandom));
        b = 2 * a * t;
        c = a * t * t + $signed(DW'($urandom_range(6))) - 3;
      end
      8: begin
        a = 0; b = $urandom; c = $urandom;
      end
      default: begin
        a = $signed(17'($urandom)); b = $signed(12'($urandom));
        c = a;
      end
    endcase
    send_coefs(a, b, c, 1'b0, none);
  endtask

  coef_row_t dir_rows[] = '{
    '{0, 0, 0, 1, '{0, 0, qrs_pkg::ST_A_ZERO}},
    '{0, 32'sh8000_0000, 32'sh7fff_ffff, 1, '{0, 0, qrs_pkg::ST_A_ZERO}},
    '{32'sh0001_0000, 0, 32'sh0001_0000, 1, '{0, 0, qrs_pkg::ST_NEG_DISC}},
    '{32'sh7fff_ffff, 0, 32'sh7fff_ffff, 1, '{0, 0, qrs_pkg::ST_NEG_DISC}},
    '{32'sh8000_0000, 0, 32'sh8000_0000, 1, '{0, 0, qrs_pkg::ST_NEG_DISC}},
    '{1, 0, 1, 1, '{0, 0, qrs_pkg::ST_NEG_DISC}},
    '{32'sh0001_0000, 0, 0, 1, '{0, 0, qrs_pkg::ST_OK}},
    '{32'sh0001_0000, -32'sh0003_0000, 32'sh0002_0000, 1,
      '{32'sh0001_0000, 32'sh0002_0000, qrs_pkg::ST_OK}},
    '{1, 32'sh7fff_ffff, 0, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{1, 32'sh8000_0000, 32'sh7fff_ffff, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{-1, 32'sh8000_0000, 32'sh8000_0000, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{-32'sh0001_0000, 32'sh0001_0000, 32'sh0002_0000, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{32'sh0001_0000, 32'sh0002_0000, 32'sh0001_0000, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{3, 7, -5, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{-1, -1, -1, 0, '{0, 0, qrs_pkg::ST_OK}},
    '{32'sh0000_8000, -32'sh0001_0000, 32'sh0000_8000, 0, '{0, 0, qrs_pkg::ST_OK}}
  };

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      m_axis_tready_i <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result check, oldest expectation first
  always @(posedge clk_i) begin
    roots_t e;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_roots.size() == 0) begin
        $error("unexpected result beat");
        n_errors++;
      end else begin
        e = pending_roots.pop_front();
        if (m_axis_tdata_o[DW-1:0] !== e.root_minus) begin
          $error("root_minus expected %h actual %h", e.root_minus, m_axis_tdata_o[DW-1:0]);
          n_errors++;
        end
        if (m_axis_tdata_o[2*DW-1:DW] !== e.root_plus) begin
          $error("root_plus expected %h actual %h", e.root_plus, m_axis_tdata_o[2*DW-1:DW]);
          n_errors++;
        end
        if (m_axis_tuser_o !== e.status) begin
          $error("status expected %0d actual %0d", e.status, m_axis_tuser_o);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on either side
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        !rst_ni || cfg_we_i)
      wdog <= 0;
    else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table at reset tolerance, no idling
    foreach (dir_rows[i])
      send_coefs(dir_rows[i].a, dir_rows[i].b, dir_rows[i].c, dir_rows[i].fixed,
                 dir_rows[i].res);

    // tolerance 0: nothing snapped
    write_tol('0);
    for (int i = 0; i < N_PHASE; i++) send_random();

    // widest tolerance, sender idling
    write_tol('1);
    idle_pct = 52;
    for (int i = 0; i < N_PHASE; i++) send_random();

    // receiver stalls, with one long hold-off to back the pipeline up
    write_tol(qrs_pkg::TOL_WIDTH'($urandom_range(16)));
    idle_pct  = 0;
    stall_pct = 52;
    hold_cnt  = HOLD_LEN;
    for (int i = 0; i < N_PHASE; i++) send_random();

    // both sides idling lightly
    write_tol(qrs_pkg::TOL_WIDTH'($urandom));
    idle_pct  = 10;
    stall_pct = 10;
    for (int i = 0; i < N_PHASE; i++) send_random();
    s_axis_tvalid_i <= 1'b0;

    wait (pending_roots.size() == 0);
    repeat (LATENCY + 8) @(posedge clk_i);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
